// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, types and codes of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = ROWS * COLUMNS;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  // Field and storage widths
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;           // {attr, char}
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CUR_W  = $clog2(CELLS + 1);          // cursor may sit one past the end
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 11;                         // read_index field
  localparam int POS_W  = 11;                         // cursor_pos field
  localparam int CMP_W  = (CUR_W > IDX_W) ? CUR_W : IDX_W;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

  // Configuration register index (word address bit)
  localparam logic REG_TEXT_ATTR = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT       = 2'd0,
    ACT_BACKSPACE = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_t;

  typedef struct packed {
    logic   start;
    sweep_t kind;
  } sweep_cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR,
    ST_RESP
  } state_t;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tcw_sweep.sv =====
// Whole-screen sweep engine: reset fill, clear fill and one-row scroll.
`timescale 1ns / 1ps
module tcw_sweep import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sweep_cmd_t        cmd,
  input  logic [ATTR_W-1:0] attr,
  input  logic [CELL_W-1:0] rd_data,
  output logic              busy,
  output ram_req_t          req
);

  localparam logic [ADDR_W-1:0] IDX_END  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(LAST_ROW_BASE);

  logic              active_r;
  logic              issue_r;
  sweep_t            kind_r;
  logic [ADDR_W-1:0] idx_r;
  logic              wpend_r;
  logic [ADDR_W-1:0] widx_r;
  logic              wlast_r;

  logic              idx_is_end;
  logic              in_last;
  logic [ADDR_W-1:0] src;
  logic [ATTR_W-1:0] fill_attr;

  always_comb begin
    idx_is_end = (idx_r == IDX_END);
    in_last    = (idx_r >= IDX_LAST);
    src        = in_last ? idx_r : idx_r + ADDR_W'(COLUMNS);
    fill_attr  = (kind_r == SW_CLEAR) ? attr : '0;
    req        = '0;
    // fill: one blank cell per cycle
    if (issue_r && kind_r != SW_SCROLL) begin
      req.we    = 1'b1;
      req.waddr = idx_r;
      req.wdata = {fill_attr, BLANK_CHAR};
    end
    // scroll: read the cell one row down (or the cell itself on the last row)
    if (issue_r && kind_r == SW_SCROLL) begin
      req.re    = 1'b1;
      req.raddr = src;
    end
    // scroll write-back, in the cycle after the read
    if (wpend_r) begin
      req.we    = 1'b1;
      req.waddr = widx_r;
      req.wdata = wlast_r ? {rd_data[CELL_W-1 -: ATTR_W], BLANK_CHAR} : rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      issue_r  <= 1'b1;
      kind_r   <= SW_INIT;
      idx_r    <= '0;
      wpend_r  <= 1'b0;
    end else begin
      wpend_r <= issue_r && (kind_r == SW_SCROLL);
      if (cmd.start) begin
        active_r <= 1'b1;
        issue_r  <= 1'b1;
        kind_r   <= cmd.kind;
        idx_r    <= '0;
      end else if (issue_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_is_end) begin
          issue_r <= 1'b0;
          if (kind_r != SW_SCROLL) begin
            active_r <= 1'b0;
          end
        end
      end
      if (wpend_r && widx_r == IDX_END) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    widx_r  <= idx_r;
    wlast_r <= in_last;
  end

  assign busy = active_r;

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: handshakes, cursor, control and cell store.
`timescale 1ns / 1ps
// Text-mode console, ROWS x COLUMNS cells of {attribute, character} in one RAM.
// Input channel (in_*): one word per command. in_tuser carries the action
// (put, backspace, clear, read); in_tdata carries the character and read index.
// Output channel (out_*): one word per command, cursor plus the read cell
// (cell fields are zero for everything but a read).
// Config (cfg_*): APB, one register, text_attribute at address 0.
// Sequence per command:
//   put (no scroll) / backspace: result loaded at the accept edge.
//   read: RAM read, capture, load.
//   put with scroll pending: the sweep engine copies each cell one row up and
//   blanks the last row, at one RAM read and one write per cycle.
//   clear: one cell written per cycle.
// Reset: the cell store is filled with blanks by a pass over all CELLS cells;
// in_tready stays low until it finishes. Config writes are taken throughout.
// The result sits in an output register; a new word is accepted only while that
// register is empty or its word is taken in the same cycle, so while the receiver
// stalls with a word held there, in_tready stays low.
module text_console_writer import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] char_code, [18:8] read_index, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [10:0] cursor_pos, [18:11] cell_char, [26:19] cell_attr
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------- configuration register ----------------
  logic [ATTR_W-1:0] attr_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_TEXT_ATTR);
  assign cfg_prdata = (cfg_paddr[2] == REG_TEXT_ATTR) ? {24'd0, attr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_wr) begin
      attr_r <= cfg_pwdata[ATTR_W-1:0];
    end
  end

  // ---------------- input word fields ----------------
  action_t           in_action;
  logic [CHAR_W-1:0] in_char;
  logic [IDX_W-1:0]  in_index;

  assign in_action = action_t'(in_tuser);
  assign in_char   = in_tdata[7:0];
  assign in_index  = in_tdata[18:8];

  // ---------------- state ----------------
  state_t            state_r, state_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [CELL_W-1:0] out_cell_r;

  // RAM and sweep engine
  sweep_cmd_t        sw_cmd;
  logic              sw_busy;
  ram_req_t          sw_req, top_req, ram_req;
  logic [CELL_W-1:0] rd_data;

  // ---------------- put / backspace arithmetic ----------------
  logic              use_scroll_base;
  logic [CUR_W-1:0]  base_cur;
  logic [ROW_W-1:0]  base_row;
  logic [COL_W-1:0]  base_col;
  logic [CHAR_W-1:0] put_ch;
  logic [CUR_W-1:0]  put_cur;
  logic [ROW_W-1:0]  put_row;
  logic [COL_W-1:0]  put_col;
  logic              put_we;

  logic [CUR_W-1:0]  bs_cur;
  logic [ROW_W-1:0]  bs_row;
  logic [COL_W-1:0]  bs_col;

  always_comb begin
    // after a scroll the cursor restarts at the head of the last row
    use_scroll_base = (state_r == ST_SCROLL);
    base_cur = use_scroll_base ? CUR_W'(LAST_ROW_BASE) : cursor_r;
    base_row = use_scroll_base ? ROW_W'(ROWS - 1) : row_r;
    base_col = use_scroll_base ? '0 : col_r;
    put_ch   = use_scroll_base ? ch_r : in_char;
    if (put_ch == NEWLINE_CHAR) begin
      put_we  = 1'b0;
      put_cur = base_cur + CUR_W'(COLUMNS) - CUR_W'(base_col);
      put_row = base_row + 1'b1;
      put_col = '0;
    end else begin
      put_we  = 1'b1;
      put_cur = base_cur + 1'b1;
      if (base_col == COL_W'(COLUMNS - 1)) begin
        put_col = '0;
        put_row = base_row + 1'b1;
      end else begin
        put_col = base_col + 1'b1;
        put_row = base_row;
      end
    end

    bs_cur = cursor_r - 1'b1;
    if (col_r == '0) begin
      bs_col = COL_W'(COLUMNS - 1);
      bs_row = row_r - 1'b1;
    end else begin
      bs_col = col_r - 1'b1;
      bs_row = row_r;
    end
  end

  // ---------------- control ----------------
  logic              out_free;
  logic              accept;
  logic              load_out;
  logic [CELL_W-1:0] load_cell;
  logic              scroll_pending;
  logic              rd_in_range;

  assign out_free       = !out_valid_r || out_tready;
  assign in_tready      = (state_r == ST_IDLE) && !sw_busy && out_free;
  assign accept         = in_tvalid && in_tready;
  assign scroll_pending = (row_r == ROW_W'(ROWS));
  assign rd_in_range    = CMP_W'(in_index) < CMP_W'(CELLS);

  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    ch_nxt     = ch_r;
    rd_ok_nxt  = rd_ok_r;
    cell_nxt   = cell_r;
    top_req    = '0;
    sw_cmd     = '0;
    load_out   = 1'b0;
    load_cell  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_PUT: begin
              if (scroll_pending) begin
                sw_cmd.start = 1'b1;
                sw_cmd.kind  = SW_SCROLL;
                ch_nxt       = in_char;
                state_nxt    = ST_SCROLL;
              end else begin
                top_req.we    = put_we;
                top_req.waddr = ADDR_W'(base_cur);
                top_req.wdata = {attr_r, put_ch};
                cursor_nxt    = put_cur;
                row_nxt       = put_row;
                col_nxt       = put_col;
                load_out      = 1'b1;
              end
            end
            ACT_BACKSPACE: begin
              if (cursor_r != '0) begin
                top_req.we    = 1'b1;
                top_req.waddr = ADDR_W'(bs_cur);
                top_req.wdata = {attr_r, BLANK_CHAR};
                cursor_nxt    = bs_cur;
                row_nxt       = bs_row;
                col_nxt       = bs_col;
              end
              load_out = 1'b1;
            end
            ACT_CLEAR: begin
              sw_cmd.start = 1'b1;
              sw_cmd.kind  = SW_CLEAR;
              cursor_nxt   = '0;
              row_nxt      = '0;
              col_nxt      = '0;
              state_nxt    = ST_CLEAR;
            end
            ACT_READ: begin
              rd_ok_nxt     = rd_in_range;
              top_req.re    = rd_in_range;
              top_req.raddr = ADDR_W'(in_index);
              state_nxt     = ST_READ;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        cell_nxt  = rd_ok_r ? rd_data : '0;
        state_nxt = ST_RESP;
      end
      ST_SCROLL: begin
        if (!sw_busy) begin
          top_req.we    = put_we;
          top_req.waddr = ADDR_W'(base_cur);
          top_req.wdata = {attr_r, put_ch};
          cursor_nxt    = put_cur;
          row_nxt       = put_row;
          col_nxt       = put_col;
          cell_nxt      = '0;
          state_nxt     = ST_RESP;
        end
      end
      ST_CLEAR: begin
        if (!sw_busy) begin
          cell_nxt  = '0;
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_cell = cell_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r    <= ch_nxt;
    rd_ok_r <= rd_ok_nxt;
    cell_r  <= cell_nxt;
    if (load_out) begin
      out_pos_r  <= POS_W'(cursor_nxt);
      out_cell_r <= load_cell;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cell_r[CELL_W-1 -: ATTR_W], out_cell_r[CHAR_W-1:0],
                       out_pos_r};

  // ---------------- cell store ----------------
  tcw_sweep u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (sw_cmd),
    .attr    (attr_r),
    .rd_data (rd_data),
    .busy    (sw_busy),
    .req     (sw_req)
  );

  // the engine owns the RAM while it sweeps
  assign ram_req = sw_busy ? sw_req : top_req;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // ---------------- assertions ----------------
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_W'(CELLS))
    else $error("cursor beyond end of screen");

  a_cursor_split: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cursor_r) == int'(row_r) * COLUMNS + int'(col_r))
    else $error("cursor row/column out of step with linear cursor");

  a_sweep_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sw_cmd.start |-> !sw_busy)
    else $error("sweep started while engine busy");

  a_scroll_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_PUT && scroll_pending) |=> (state_r == ST_SCROLL && sw_busy))
    else $error("put with scroll pending did not start a scroll");

endmodule
